FILE: hw/rtl/cosine_hemisphere_warp_defines.svh
// assertion macros for the cosine hemisphere warp
`ifndef COSINE_HEMISPHERE_WARP_DEFINES_SVH
`define COSINE_HEMISPHERE_WARP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CHW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/chw_pkg.sv
// shared types and constants for the cosine hemisphere warp
package chw_pkg;

  typedef struct packed {
    logic [15:0] sample_u;
    logic [15:0] sample_v;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [14:0]        dir_z;
  } dir_t;

  localparam int SQRT_STEPS   = 16;
  localparam int ATAN_ENTRIES = 24;

  // reciprocal of the limit cordic gain in q0.30
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam logic [14:0] Z_MAX = 15'd32767;

  // quadrant codes, in quarter turns
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic signed [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

FILE: hw/rtl/cosine_hemisphere_warp.sv
// cosine-weighted hemisphere warp: top level pipeline
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  sample   | sample_valid / sample_ready | chw_pkg::sample_t (u, v)
//  dir      | dir_valid / dir_ready       | chw_pkg::dir_t (x, y, z)
//
// one transfer per cycle sustained while the sink accepts. stages: 16 root
// digit stages, one gain multiply, one per cordic step (min(ROTATION_STEPS, 24)),
// one output stage. every stage has its own valid bit and loads whenever it is
// empty or its successor loads, so bubbles are squeezed out during a stall and
// nothing is dropped or repeated. reset clears the valid bits only.
module cosine_hemisphere_warp #(
  parameter int FRAC_BITS      = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  chw_pkg::sample_t  sample,
  output logic              dir_valid,
  input  logic              dir_ready,
  output chw_pkg::dir_t     dir
);

`include "cosine_hemisphere_warp_defines.svh"

  // cordic steps actually run, capped at the size of the arctangent table
  localparam int STEPS = (ROTATION_STEPS > chw_pkg::ATAN_ENTRIES) ?
                         chw_pkg::ATAN_ENTRIES : ROTATION_STEPS;
  localparam int SQ_N    = chw_pkg::SQRT_STEPS;
  localparam int MUL_IDX = SQ_N;
  localparam int COR0    = SQ_N + 1;
  localparam int OUT_IDX = SQ_N + 1 + STEPS;
  localparam int NST     = OUT_IDX + 1;

  // datapath width: magnitudes stay below 2^(FRAC_BITS+1)
  localparam int CW = FRAC_BITS + 3;
  // width for q1.15 conversion, grown when scaling up
  localparam int DN = (FRAC_BITS > 15) ? FRAC_BITS - 15 : 0;
  localparam int UP = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
  localparam int QW = CW + UP;
  localparam int HALF_SH = (DN > 0) ? DN - 1 : 0;
  localparam logic signed [QW-1:0] HALF  = (DN > 0) ? (QW'(1) << HALF_SH) : '0;
  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(32767);
  localparam int GAIN_SH = 45 - FRAC_BITS;

  // ---------------------------------------------------------------------------
  // flow control: per-stage valid and load enable
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic [NST-1:0] vld_prev;

  assign en[NST-1] = ~vld[NST-1] | dir_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = ~vld[k] | en[k+1];
  end

  assign vld_prev = {vld[NST-2:0], sample_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld_prev[k];
        end
      end
    end
  end

  assign sample_ready = en[0];
  assign dir_valid    = vld[OUT_IDX];

  // ---------------------------------------------------------------------------
  // azimuth: nearest quarter turn split off, residual kept as binary angle
  // ---------------------------------------------------------------------------
  logic [15:0]        v_round;
  logic [1:0]         init_quad;
  logic signed [31:0] init_ang;

  assign v_round   = sample.sample_v + 16'h2000;
  assign init_quad = v_round[15:14];
  assign init_ang  = $signed({sample.sample_v - {init_quad, 14'd0}, 16'd0});

  // ---------------------------------------------------------------------------
  // square roots of u and 1-u, one digit per stage, both in parallel
  // ---------------------------------------------------------------------------
  logic [31:0]        nz    [SQ_N];
  logic [31:0]        rz    [SQ_N];
  logic [31:0]        ns    [SQ_N];
  logic [31:0]        rs    [SQ_N];
  logic signed [31:0] sang  [SQ_N];
  logic [1:0]         squad [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [31:0]        nz_i, rz_i, ns_i, rs_i;
    logic [31:0]        nz_next, rz_next, ns_next, rs_next;
    logic signed [31:0] ang_i;
    logic [1:0]         quad_i;

    if (k == 0) begin : g_first
      assign nz_i   = {2'b0, sample.sample_u, 14'b0};
      assign ns_i   = {15'b0, 17'h10000 - {1'b0, sample.sample_u}} << 14;
      assign rz_i   = '0;
      assign rs_i   = '0;
      assign ang_i  = init_ang;
      assign quad_i = init_quad;
    end else begin : g_rest
      assign nz_i   = nz[k-1];
      assign ns_i   = ns[k-1];
      assign rz_i   = rz[k-1];
      assign rs_i   = rs[k-1];
      assign ang_i  = sang[k-1];
      assign quad_i = squad[k-1];
    end

    chw_isqrt_step #(.STEP(k)) u_root_z (
      .rem       (nz_i),
      .root      (rz_i),
      .rem_next  (nz_next),
      .root_next (rz_next)
    );

    chw_isqrt_step #(.STEP(k)) u_root_s (
      .rem       (ns_i),
      .root      (rs_i),
      .rem_next  (ns_next),
      .root_next (rs_next)
    );

    always_ff @(posedge clk) begin
      if (en[k]) begin
        nz[k]    <= nz_next;
        rz[k]    <= rz_next;
        ns[k]    <= ns_next;
        rs[k]    <= rs_next;
        sang[k]  <= ang_i;
        squad[k] <= quad_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // gain pre-scale of sin theta, and saturation of cos theta
  // ---------------------------------------------------------------------------
  logic [45:0]        prod;
  logic [14:0]        z_sat;
  logic signed [CW-1:0] mx;
  logic [14:0]        mz;
  logic signed [31:0] mang;
  logic [1:0]         mquad;

  assign prod  = rs[SQ_N-1][15:0] * chw_pkg::GAIN_Q30;
  assign z_sat = (rz[SQ_N-1] > 32'(chw_pkg::Z_MAX)) ? chw_pkg::Z_MAX : rz[SQ_N-1][14:0];

  always_ff @(posedge clk) begin
    if (en[MUL_IDX]) begin
      mx    <= $signed(CW'(prod >> GAIN_SH));
      mz    <= z_sat;
      mang  <= sang[SQ_N-1];
      mquad <= squad[SQ_N-1];
    end
  end

  // ---------------------------------------------------------------------------
  // cordic rotation by the residual angle, one step per stage
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] cx    [STEPS];
  logic signed [CW-1:0] cy    [STEPS];
  logic signed [31:0]   cang  [STEPS];
  logic [1:0]           cquad [STEPS];
  logic [14:0]          cz    [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_cordic
    logic signed [CW-1:0] x_i, y_i, x_next, y_next;
    logic signed [31:0]   ang_i, ang_next;
    logic [1:0]           quad_i;
    logic [14:0]          z_i;

    if (j == 0) begin : g_first
      assign x_i    = mx;
      assign y_i    = '0;
      assign ang_i  = mang;
      assign quad_i = mquad;
      assign z_i    = mz;
    end else begin : g_rest
      assign x_i    = cx[j-1];
      assign y_i    = cy[j-1];
      assign ang_i  = cang[j-1];
      assign quad_i = cquad[j-1];
      assign z_i    = cz[j-1];
    end

    chw_cordic_step #(
      .W     (CW),
      .SHIFT (j),
      .ATAN  (chw_pkg::ATAN_TURNS[j])
    ) u_step (
      .x        (x_i),
      .y        (y_i),
      .ang      (ang_i),
      .x_next   (x_next),
      .y_next   (y_next),
      .ang_next (ang_next)
    );

    always_ff @(posedge clk) begin
      if (en[COR0+j]) begin
        cx[j]    <= x_next;
        cy[j]    <= y_next;
        cang[j]  <= ang_next;
        cquad[j] <= quad_i;
        cz[j]    <= z_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // quarter-turn swap, q1.15 rounding (half up) and symmetric saturation
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] ox, oy;
  logic signed [QW-1:0] qx, qy;
  chw_pkg::dir_t        dir_next;

  function automatic logic signed [QW-1:0] to_q15(input logic signed [CW-1:0] val);
    logic signed [QW-1:0] w;
    w = QW'(val);
    w = (w + HALF) >>> DN;
    w = w <<< UP;
    if (w > Q_MAX) begin
      w = Q_MAX;
    end else if (w < Q_MIN) begin
      w = Q_MIN;
    end
    return w;
  endfunction

  always_comb begin
    unique case (cquad[STEPS-1])
      chw_pkg::QUAD_0: begin ox = cx[STEPS-1];  oy = cy[STEPS-1];  end
      chw_pkg::QUAD_1: begin ox = -cy[STEPS-1]; oy = cx[STEPS-1];  end
      chw_pkg::QUAD_2: begin ox = -cx[STEPS-1]; oy = -cy[STEPS-1]; end
      chw_pkg::QUAD_3: begin ox = cy[STEPS-1];  oy = -cx[STEPS-1]; end
      default:         begin ox = cx[STEPS-1];  oy = cy[STEPS-1];  end
    endcase
  end

  assign qx = to_q15(ox);
  assign qy = to_q15(oy);

  always_comb begin
    dir_next.dir_x = qx[15:0];
    dir_next.dir_y = qy[15:0];
    dir_next.dir_z = cz[STEPS-1];
  end

  // output register: holds the finished result while the sink stalls
  always_ff @(posedge clk) begin
    if (en[OUT_IDX]) begin
      dir <= dir_next;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // an empty output stage lets the whole pipe advance
  `CHW_ASSERT_NOW(a_empty_out_ready, !dir_valid, sample_ready, "pipe blocked with empty output")
  // a result transfer always frees the entry stage
  `CHW_ASSERT_NOW(a_drain_ready, dir_valid && dir_ready, sample_ready, "entry stalled on drain")
  // saturation keeps x and y off full negative scale
  `CHW_ASSERT_NOW(a_sat_xy, dir_valid,
                  (dir.dir_x != 16'sh8000) && (dir.dir_y != 16'sh8000),
                  "x or y left unsaturated")
  // a stalled result cannot vanish
  `CHW_ASSERT_NEXT(a_hold_valid, dir_valid && !dir_ready, dir_valid, "stalled result lost")

endmodule

FILE: hw/rtl/chw_isqrt_step.sv
// one digit step of the bitwise integer square root
module chw_isqrt_step #(
  parameter int STEP = 0
) (
  input  logic [31:0] rem,
  input  logic [31:0] root,
  output logic [31:0] rem_next,
  output logic [31:0] root_next
);

  localparam logic [31:0] BIT = 32'd1 << (30 - 2 * STEP);

  logic [31:0] trial;

  assign trial = root + BIT;

  always_comb begin
    if (rem >= trial) begin
      rem_next  = rem - trial;
      root_next = (root >> 1) + BIT;
    end else begin
      rem_next  = rem;
      root_next = root >> 1;
    end
  end

endmodule

FILE: hw/rtl/chw_cordic_step.sv
// one micro-rotation of the cordic rotator
module chw_cordic_step #(
  parameter int                 W     = 19,
  parameter int                 SHIFT = 0,
  parameter logic signed [31:0] ATAN  = 32'sd0
) (
  input  logic signed [W-1:0] x,
  input  logic signed [W-1:0] y,
  input  logic signed [31:0]  ang,
  output logic signed [W-1:0] x_next,
  output logic signed [W-1:0] y_next,
  output logic signed [31:0]  ang_next
);

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;

  assign dx = y >>> SHIFT;
  assign dy = x >>> SHIFT;

  always_comb begin
    if (!ang[31]) begin
      x_next   = x - dx;
      y_next   = y + dy;
      ang_next = ang - ATAN;
    end else begin
      x_next   = x + dx;
      y_next   = y - dy;
      ang_next = ang + ATAN;
    end
  end

endmodule
